// ===== design/spmq_pkg.sv =====
// Shared types, constants and widths of the strict-priority multi-queue.
package spmq_pkg;

  localparam int NUM_LEVELS  = 16;
  localparam int QUEUE_DEPTH = 128;

  localparam int VALUE_W  = 32;
  localparam int LEVEL_W  = 4;
  localparam int STATUS_W = 3;

  // internal level index, head pointer and fill count widths
  localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_D = NUM_LEVELS * QUEUE_DEPTH;
  localparam int STORE_AW = (STORE_D > 1) ? $clog2(STORE_D) : 1;

  localparam int IN_TDATA_W  = ((VALUE_W + LEVEL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + LEVEL_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_INVALID  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,
    S_DATA,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [HEAD_W-1:0] head;
  } ptr_t;

  typedef struct packed {
    status_t                    status;
    logic [LEVEL_W-1:0]         level;
    logic signed [VALUE_W-1:0]  value;
  } res_t;

  // pointer table access from the control logic
  typedef struct packed {
    logic             rd_en;
    logic [LVL_W-1:0] rd_addr;
    logic             wr_en;
    logic [LVL_W-1:0] wr_addr;
    ptr_t             wr_data;
  } ptr_req_t;

endpackage

// ===== design/strict_priority_multi_queue_core.sv =====
// Strict-priority multi-queue: one ring FIFO per level in a shared entry RAM.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser: command; tdata: value, priority_req
//  out_    | out | out_tvalid/out_tready| tuser: status; tdata: out_value, out_level
//  cfg_    | in  | cfg_valid/cfg_ready  | data: max_level
//
// Insert: read of the level's pointer entry, write-back unless full. Remove: the
// same read, write-back with an entry RAM read. Invalid/empty: neither is touched.
// One request is in flight at a time; the next is taken once the result is in
// the output register. A stalled output holds the result and the block waits.
// Reset is synchronous: pointers read as empty, max_level returns to 15;
// the entry RAM needs no clearing.
module strict_priority_multi_queue_core
  import spmq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value, [35:32] priority_req
  input  logic [0:0]             in_tuser,   // [0] command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] out_value, [35:32] out_level
  output logic [STATUS_W-1:0]    out_tuser,  // [2:0] status
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LEVEL_W-1:0]     cfg_data
);

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  res_t                  res_r, res_nxt;
  res_t                  out_res_r, out_res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [LEVEL_W-1:0]    max_level_r;

  logic                  in_acc;
  logic                  out_free;
  logic [VALUE_W-1:0]    in_value;
  logic [LEVEL_W-1:0]    in_prio;
  logic                  in_invalid;
  logic                  found;
  logic [LVL_W-1:0]      found_lvl;

  ptr_req_t              ptr_req;
  ptr_t                  ptr_q;

  logic                  st_wr_en, st_rd_en;
  logic [STORE_AW-1:0]   st_wr_addr, st_rd_addr;
  logic [VALUE_W-1:0]    st_q;

  logic [CNT_W:0]        pos_sum;
  logic [HEAD_W-1:0]     tail_pos;
  logic [HEAD_W-1:0]     head_inc;
  logic [STORE_AW-1:0]   lvl_base;

  assign in_value  = in_tdata[VALUE_W-1:0];
  assign in_prio   = in_tdata[VALUE_W +: LEVEL_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign in_invalid = (int'(in_prio) > int'(max_level_r)) || (int'(in_prio) >= NUM_LEVELS);

  // lowest-numbered non-empty level within max_level
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i] && (i <= int'(max_level_r))) begin
        found     = 1'b1;
        found_lvl = LVL_W'(i);
      end
    end
  end

  // ring arithmetic; count < depth on insert, so one subtract wraps
  assign pos_sum  = (CNT_W + 1)'(ptr_q.head) + (CNT_W + 1)'(ptr_q.count);
  assign tail_pos = (int'(pos_sum) >= QUEUE_DEPTH) ?
                    HEAD_W'(pos_sum - (CNT_W + 1)'(QUEUE_DEPTH)) : HEAD_W'(pos_sum);
  assign head_inc = (int'(ptr_q.head) == QUEUE_DEPTH - 1) ? '0 : ptr_q.head + 1'b1;
  assign lvl_base = STORE_AW'(int'(lvl_r) * QUEUE_DEPTH);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    lvl_nxt       = lvl_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    nonempty_nxt  = nonempty_r;
    ptr_req       = '0;
    st_wr_en      = 1'b0;
    st_wr_addr    = lvl_base + STORE_AW'(tail_pos);
    st_rd_en      = 1'b0;
    st_rd_addr    = lvl_base + STORE_AW'(ptr_q.head);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = cmd_t'(in_tuser[0]);
          val_nxt = in_value;
          if (cmd_t'(in_tuser[0]) == CMD_INSERT) begin
            lvl_nxt = LVL_W'(in_prio);
            if (in_invalid) begin
              res_nxt   = '{status: ST_INVALID, level: '0, value: '0};
              state_nxt = S_RESP;
            end else begin
              ptr_req.rd_en   = 1'b1;
              ptr_req.rd_addr = LVL_W'(in_prio);
              state_nxt       = S_PTR;
            end
          end else begin
            lvl_nxt = found_lvl;
            if (!found) begin
              res_nxt   = '{status: ST_EMPTY, level: '0, value: '0};
              state_nxt = S_RESP;
            end else begin
              ptr_req.rd_en   = 1'b1;
              ptr_req.rd_addr = found_lvl;
              state_nxt       = S_PTR;
            end
          end
        end
      end

      S_PTR: begin
        if (cmd_r == CMD_INSERT) begin
          if (int'(ptr_q.count) >= QUEUE_DEPTH) begin
            res_nxt = '{status: ST_FULL, level: '0, value: '0};
          end else begin
            res_nxt               = '{status: ST_INSERTED, level: '0, value: '0};
            st_wr_en              = 1'b1;
            ptr_req.wr_en         = 1'b1;
            ptr_req.wr_addr       = lvl_r;
            ptr_req.wr_data.head  = ptr_q.head;
            ptr_req.wr_data.count = ptr_q.count + 1'b1;
            nonempty_nxt[lvl_r]   = 1'b1;
          end
          if (out_free) begin
            out_res_nxt   = res_nxt;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          // level is known non-empty here
          st_rd_en              = 1'b1;
          ptr_req.wr_en         = 1'b1;
          ptr_req.wr_addr       = lvl_r;
          ptr_req.wr_data.head  = head_inc;
          ptr_req.wr_data.count = ptr_q.count - 1'b1;
          nonempty_nxt[lvl_r]   = (ptr_q.count != CNT_W'(1));
          state_nxt             = S_DATA;
        end
      end

      S_DATA: begin
        res_nxt = '{status: ST_REMOVED, level: LEVEL_W'(lvl_r), value: st_q};
        if (out_free) begin
          out_res_nxt   = res_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nonempty_r  <= '0;
      max_level_r <= LEVEL_W'(15);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nonempty_r  <= nonempty_nxt;
      if (cfg_valid && cfg_ready) begin
        max_level_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    lvl_r     <= lvl_nxt;
    val_r     <= val_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  spmq_ptr_table u_ptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ptr_req),
    .rd_data (ptr_q)
  );

  spmq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_D),
    .AW    (STORE_AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (val_r),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.level, out_res_r.value});
  assign out_tuser  = out_res_r.status;

endmodule

// ===== design/spmq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/spmq_ptr_table.sv =====
// Per-level head/count table: small RAM plus reset-cleared valid bits.
module spmq_ptr_table
  import spmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ptr_req_t req,
  output ptr_t     rd_data
);

  localparam int PTR_W = $bits(ptr_t);

  logic [NUM_LEVELS-1:0] vld_r;
  logic [NUM_LEVELS-1:0] vld_nxt;
  logic                  rd_vld_r;
  logic [PTR_W-1:0]      ram_q;

  spmq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_LEVELS),
    .AW    (LVL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // never-written level reads as empty ring at head zero
  assign rd_data = rd_vld_r ? ptr_t'(ram_q) : '0;

endmodule

// ===== design/spmq_checker.sv =====
// Port-level checks for the strict-priority multi-queue, bound to the top level.
module spmq_checker
  import spmq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request in flight: busy in the cycle after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in flight");

  // only a removal carries value and level
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_REMOVED) |-> (out_tdata == '0))
    else $error("non-remove result carries payload");

endmodule

bind strict_priority_multi_queue_core spmq_checker u_spmq_checker (.*);
